>>> design/bmhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmhpq_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = ADDR_W + 1;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAYLOAD_W = 16;
  localparam int unsigned STATUS_W  = 2;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_SERVE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;
  } entry_t;

endpackage

`default_nettype wire

>>> design/bmhpq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bmhpq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [bmhpq_pkg::KEY_W-1:0]    key;
  logic [bmhpq_pkg::PAYLOAD_W-1:0]       payload;

  modport source (output valid, req_type, key, payload, input ready);
  modport sink   (input valid, req_type, key, payload, output ready);
endinterface

interface bmhpq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bmhpq_pkg::KEY_W-1:0]    out_key;
  logic [bmhpq_pkg::PAYLOAD_W-1:0]       out_payload;
  logic [bmhpq_pkg::STATUS_W-1:0]        status;
  logic [bmhpq_pkg::CNT_W-1:0]           fill_count;

  modport source (output valid, out_key, out_payload, status, fill_count, input ready);
  modport sink   (input valid, out_key, out_payload, status, fill_count, output ready);
endinterface

interface bmhpq_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [bmhpq_pkg::CNT_W-1:0]           capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

>>> design/binary_min_heap_priority_queue.sv
// A dropped append, an empty serve or an append to an empty heap answers in the cycle after it
// is taken; an append sifts up and a serve sifts down, one heap level per cycle, and the last
// step waits while the result side holds off the finished item.
// One item at a time: the next is taken once the queue is idle and the result register is free.
// Each heap level uses the single entry memory: a read, a compare and a write.
// Reset clears the fill count, the controller and the output valid; capacity resets to 64.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_priority_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  bmhpq_req_if.sink        req_i,
  bmhpq_rsp_if.source      rsp_o,
  bmhpq_cfg_if.sink        cfg_i
);

  localparam int unsigned ADDR_W = bmhpq_pkg::ADDR_W;
  localparam int unsigned CNT_W  = bmhpq_pkg::CNT_W;
  localparam int unsigned IDX_W  = ADDR_W + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_CMP  = 3'd1;
  localparam logic [2:0] S_DN_LOAD = 3'd2;
  localparam logic [2:0] S_DN_CMP  = 3'd3;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] idx);
    parent_of = (idx - ADDR_W'(1)) >> 1;
  endfunction

  // entry memory
  bmhpq_pkg::entry_t mem_q [bmhpq_pkg::DEPTH];
  bmhpq_pkg::entry_t rd_a_q, rd_b_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  bmhpq_pkg::entry_t wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_a_addr];
      rd_b_q <= mem_q[rd_b_addr];
    end
  end

  // control and payload registers
  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cap_q;
  logic [ADDR_W-1:0] pos_q, pos_d;
  bmhpq_pkg::entry_t ent_q, ent_d;
  bmhpq_pkg::entry_t root_q, root_d;

  logic                               rsp_valid_q;
  logic signed [bmhpq_pkg::KEY_W-1:0] rsp_key_q;
  logic [bmhpq_pkg::PAYLOAD_W-1:0]    rsp_pay_q;
  logic [bmhpq_pkg::STATUS_W-1:0]     rsp_status_q;
  logic [CNT_W-1:0]                   rsp_fill_q;

  logic                               fin;
  bmhpq_pkg::entry_t                  fin_ent;
  logic [bmhpq_pkg::STATUS_W-1:0]     fin_status;

  logic              out_free;
  logic [CNT_W-1:0]  limit;
  bmhpq_pkg::entry_t req_ent;

  // sift-down helpers
  logic [IDX_W-1:0]  left_idx, right_idx, cnt_ext;
  logic              left_ok, pick_right;
  bmhpq_pkg::entry_t pick_ent;
  logic [ADDR_W-1:0] pick_idx;
  logic [IDX_W-1:0]  next_left;
  logic [ADDR_W-1:0] par_cur;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign limit    = (cap_q > CNT_W'(bmhpq_pkg::DEPTH)) ? CNT_W'(bmhpq_pkg::DEPTH) : cap_q;
  assign req_ent  = '{key: req_i.key, payload: req_i.payload};

  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign cnt_ext    = IDX_W'(count_q);
  assign left_ok    = left_idx < cnt_ext;
  assign pick_right = (right_idx < cnt_ext) && ($signed(rd_b_q.key) < $signed(rd_a_q.key));
  assign pick_ent   = pick_right ? rd_b_q : rd_a_q;
  assign pick_idx   = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
  assign next_left  = {1'b0, pick_idx, 1'b1};
  assign par_cur    = parent_of(pos_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    ent_d      = ent_q;
    root_d     = root_q;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = ent_q;
    rd_en      = 1'b0;
    rd_a_addr  = '0;
    rd_b_addr  = '0;
    fin        = 1'b0;
    fin_ent    = '0;
    fin_status = bmhpq_pkg::STATUS_DONE;
    req_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_i.ready = out_free;
        if (req_i.valid && out_free) begin
          if (req_i.req_type == bmhpq_pkg::REQ_APPEND) begin
            if (count_q >= limit) begin
              fin        = 1'b1;
              fin_status = bmhpq_pkg::STATUS_FULL;
            end else begin
              count_d = count_q + CNT_W'(1);
              ent_d   = req_ent;
              pos_d   = count_q[ADDR_W-1:0];
              if (count_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = req_ent;
                fin     = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_a_addr = parent_of(count_q[ADDR_W-1:0]);
                state_d   = S_UP_CMP;
              end
            end
          end else begin
            if (count_q == '0) begin
              fin        = 1'b1;
              fin_status = bmhpq_pkg::STATUS_EMPTY;
            end else begin
              count_d   = count_q - CNT_W'(1);
              rd_en     = 1'b1;
              rd_a_addr = '0;
              rd_b_addr = ADDR_W'(count_q - CNT_W'(1));
              state_d   = S_DN_LOAD;
            end
          end
        end
      end

      S_UP_CMP: begin
        if (pos_q == '0) begin
          if (out_free) begin
            wr_en   = 1'b1;
            fin     = 1'b1;
            state_d = S_IDLE;
          end
        end else if ($signed(ent_q.key) < $signed(rd_a_q.key)) begin
          // move the parent down into the hole and climb
          wr_en   = 1'b1;
          wr_data = rd_a_q;
          pos_d   = par_cur;
          if (par_cur != '0) begin
            rd_en     = 1'b1;
            rd_a_addr = parent_of(par_cur);
          end
        end else if (out_free) begin
          wr_en   = 1'b1;
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_DN_LOAD: begin
        root_d = rd_a_q;
        ent_d  = rd_b_q;
        if (count_q == '0) begin
          if (out_free) begin
            fin     = 1'b1;
            fin_ent = rd_a_q;
            state_d = S_IDLE;
          end
        end else begin
          pos_d     = '0;
          rd_en     = 1'b1;
          rd_a_addr = ADDR_W'(1);
          rd_b_addr = ADDR_W'(2);
          state_d   = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        if (!left_ok || ($signed(ent_q.key) <= $signed(pick_ent.key))) begin
          if (out_free) begin
            wr_en   = 1'b1;
            fin     = 1'b1;
            fin_ent = root_q;
            state_d = S_IDLE;
          end
        end else begin
          // lift the smaller child into the hole and descend
          wr_en     = 1'b1;
          wr_data   = pick_ent;
          pos_d     = pick_idx;
          rd_en     = 1'b1;
          rd_a_addr = next_left[ADDR_W-1:0];
          rd_b_addr = ADDR_W'(next_left + IDX_W'(1));
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CNT_W'(bmhpq_pkg::DEPTH);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
      if (fin) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    ent_q  <= ent_d;
    root_q <= root_d;
    if (fin) begin
      rsp_key_q    <= fin_ent.key;
      rsp_pay_q    <= fin_ent.payload;
      rsp_status_q <= fin_status;
      rsp_fill_q   <= count_d;
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.out_key     = rsp_key_q;
  assign rsp_o.out_payload = rsp_pay_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.fill_count  = rsp_fill_q;

endmodule

`default_nettype wire
